FILE: hdl/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

  // widths fixed by the byte format
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CpW        = 31;
  localparam int unsigned HoldDepth  = 5;
  localparam int unsigned MaxResults = 6;

  // lead byte class masks and patterns
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContVal   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Val  = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Val  = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Val  = 8'hf0;
  localparam logic [7:0] Lead5Mask = 8'hfc;
  localparam logic [7:0] Lead5Val  = 8'hf8;
  localparam logic [7:0] Lead6Mask = 8'hfe;
  localparam logic [7:0] Lead6Val  = 8'hfc;
  localparam logic [7:0] LeadBits  = 8'h7f;
  localparam logic [7:0] PayBits   = 8'h3f;

  // input transaction
  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             end_of_stream;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           last_of_run;
  } out_t;

  // sequence tracking state
  typedef struct packed {
    logic [2:0] count;
    logic [2:0] exp_len;
  } state_t;

  // results of one byte, drained one per cycle while the receiver does not stall
  typedef struct packed {
    logic [MaxResults-1:0][ByteW-1:0] bytes;
    logic [CpW-1:0]                   value;
    logic                             use_value;
    logic [2:0]                       count;
  } burst_t;

  // everything one byte changes
  typedef struct packed {
    state_t           nxt;
    logic             wr_en;
    logic [2:0]       wr_idx;
    burst_t           burst;
  } step_t;

endpackage

FILE: hdl/u8d_step.sv
`timescale 1ns / 1ps

module u8d_step (
  input  u8d_pkg::in_t                                           item_i,
  input  u8d_pkg::state_t                                        state_i,
  input  logic [u8d_pkg::HoldDepth-1:0][u8d_pkg::ByteW-1:0]      pend_i,
  output u8d_pkg::step_t                                         step_o
);
  import u8d_pkg::*;

  logic [ByteW-1:0] b;
  logic             eos;
  logic [2:0]       len;
  logic             is_lead;
  logic             is_cont;
  logic             seq_open;
  logic             seq_done;
  logic [ByteW-1:0] ext [MaxResults];
  logic [ByteW-1:0] lead_m;
  logic [CpW-1:0]   acc;

  // sequence length from a lead byte, 1 for ASCII, 0 for continuation or invalid bytes
  function automatic logic [2:0] lead_len(input logic [ByteW-1:0] v);
    logic [2:0] r;
    priority if (v[7] == 1'b0)               r = 3'd1;
    else if ((v & Lead2Mask) == Lead2Val)    r = 3'd2;
    else if ((v & Lead3Mask) == Lead3Val)    r = 3'd3;
    else if ((v & Lead4Mask) == Lead4Val)    r = 3'd4;
    else if ((v & Lead5Mask) == Lead5Val)    r = 3'd5;
    else if ((v & Lead6Mask) == Lead6Val)    r = 3'd6;
    else                                     r = 3'd0;
    return r;
  endfunction

  assign b        = item_i.byte_in;
  assign eos      = item_i.end_of_stream;
  assign len      = lead_len(b);
  assign is_lead  = (len >= 3'd2);
  assign is_cont  = ((b & ContMask) == ContVal);
  assign seq_open = (state_i.count != 3'd0) && (state_i.exp_len >= 3'd2);
  assign seq_done = ((state_i.count + 3'd1) >= state_i.exp_len);

  // held bytes with the current byte placed right after them
  always_comb begin
    for (int i = 0; i < HoldDepth; i++) begin
      ext[i] = (state_i.count == 3'(i)) ? b : pend_i[i];
    end
    ext[HoldDepth] = b;
  end

  // assemble the code point: masked lead bits, then six bits per byte
  always_comb begin
    lead_m = pend_i[0] & (LeadBits >> state_i.exp_len);
    acc    = CpW'(lead_m);
    for (int i = 1; i < MaxResults; i++) begin
      if (3'(i) < state_i.exp_len) begin
        acc = {acc[CpW-7:0], ext[i][5:0]};
      end
    end
  end

  // next state and result list
  always_comb begin
    step_o                 = '0;
    step_o.burst.value     = acc;
    for (int i = 0; i < MaxResults; i++) begin
      step_o.burst.bytes[i] = ext[i];
    end
    step_o.wr_idx = state_i.count;

    priority if (!seq_open) begin
      // no open sequence: hold a lead (unless end of stream), pass anything else through raw
      if (is_lead && !eos) begin
        step_o.wr_en       = 1'b1;
        step_o.wr_idx      = 3'd0;
        step_o.nxt.count   = 3'd1;
        step_o.nxt.exp_len = len;
      end else begin
        step_o.burst.count = 3'd1;
      end
    end else if (is_cont && seq_done) begin
      // sequence complete
      step_o.burst.use_value = 1'b1;
      step_o.burst.count     = 3'd1;
    end else if (is_cont) begin
      // keep collecting, or flush everything raw at end of stream
      if (eos) begin
        step_o.burst.count = state_i.count + 3'd1;
      end else begin
        step_o.wr_en       = (state_i.count < 3'(HoldDepth));
        step_o.nxt.count   = state_i.count + 3'd1;
        step_o.nxt.exp_len = state_i.exp_len;
      end
    end else begin
      // bad continuation: flush held bytes, then treat byte as a new lead
      if (is_lead && !eos) begin
        step_o.wr_en       = 1'b1;
        step_o.wr_idx      = 3'd0;
        step_o.nxt.count   = 3'd1;
        step_o.nxt.exp_len = len;
        step_o.burst.count = state_i.count;
      end else begin
        step_o.burst.count = state_i.count + 3'd1;
      end
    end
  end

endmodule

FILE: hdl/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// Byte-serial UTF-8 decoder for the original 1 to 6 byte forms.
// Input channel: one byte per transaction (in_valid_i / in_stall_o), with an
// end_of_stream flag that flushes any held bytes raw after that byte.
// Output channel: one code point per transaction (out_valid_o / out_stall_i);
// last_of_run marks the final result caused by an input byte.
// A byte is decoded in the cycle it is accepted and its results sit in the
// result register from the next cycle on.
// A byte gives 0 to 6 results, drained one per cycle from the result register
// while the receiver does not stall; plain ASCII runs at one byte a cycle then.
// The next byte is taken in the same cycle as the last pending result leaves.
// When the receiver stalls, the current result holds and input stalls once
// the result register is still busy.
// Reset clears the sequence state and the result register; no clearing pass.
module utf8_stream_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  u8d_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output u8d_pkg::out_t   out_data_o
);
  import u8d_pkg::*;

  state_t                           state_q;
  logic [HoldDepth-1:0][ByteW-1:0]  pend_q;
  burst_t                           burst_q;
  step_t                            step;
  logic                             in_fire;
  logic                             out_fire;

  // decode step for the incoming byte
  u8d_step u_step (
    .item_i  (in_data_i),
    .state_i (state_q),
    .pend_i  (pend_q),
    .step_o  (step)
  );

  // handshakes
  assign out_valid_o = (burst_q.count != 3'd0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((burst_q.count == 3'd0) ||
                         ((burst_q.count == 3'd1) && !out_stall_i));
  assign in_fire     = in_valid_i && !in_stall_o;

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= step.nxt;
    end
  end

  // held bytes
  always_ff @(posedge clk_i) begin
    if (in_fire && step.wr_en) begin
      pend_q[step.wr_idx] <= in_data_i.byte_in;
    end
  end

  // result register: load on a new byte, shift out one per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
    end else if (in_fire) begin
      burst_q <= step.burst;
    end else if (out_fire) begin
      burst_q.count <= burst_q.count - 3'd1;
      for (int i = 0; i < MaxResults - 1; i++) begin
        burst_q.bytes[i] <= burst_q.bytes[i+1];
      end
    end
  end

  // output payload
  assign out_data_o.code_point  = burst_q.use_value ? burst_q.value
                                                    : CpW'(burst_q.bytes[0]);
  assign out_data_o.last_of_run = (burst_q.count == 3'd1);

endmodule

FILE: tb/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import u8d_pkg::*;

  localparam int CycLimit  = 200000;
  localparam int TailItems = 20;   // last stretch of the run runs without idling
  localparam int PressAt   = 40;   // bytes taken before the long receiver hold-off
  localparam int PressLen  = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  utf8_stream_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // byte stream waiting to go in, and code points waiting to come out
  in_t  byte_q[$];
  out_t code_point_q[$];

  // decoder state mirror
  logic [7:0] held_bytes [HoldDepth];
  int         held_cnt = 0;
  int         seq_len = 0;
  out_t       step_res [MaxResults];
  int         step_n;

  int   cyc = 0;
  int   errs = 0;
  int   bytes_taken = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  out_t got, want;

  // stretches of choppy traffic alternate with clean ones
  wire choppy = ((cyc / 300) % 3) != 2;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  task automatic report_mismatch(string what, logic [31:0] g, logic [31:0] w);
    $display("mismatch: %s got %h want %h (cycle %0d)", what, g, w, cyc);
    errs++;
  endtask

  function automatic int lead_len(logic [7:0] b);
    if (b < 8'h80) return 1;
    if ((b & Lead2Mask) == Lead2Val) return 2;
    if ((b & Lead3Mask) == Lead3Val) return 3;
    if ((b & Lead4Mask) == Lead4Val) return 4;
    if ((b & Lead5Mask) == Lead5Val) return 5;
    if ((b & Lead6Mask) == Lead6Val) return 6;
    return 0;
  endfunction

  task automatic add_result(logic [CpW-1:0] v);
    step_res[step_n] = '{code_point: v, last_of_run: 1'b0};
    step_n++;
  endtask

  // held bytes go out raw, lead first
  task automatic flush_held();
    for (int i = 0; i < held_cnt; i++) add_result({23'b0, held_bytes[i]});
    held_cnt = 0;
    seq_len = 0;
  endtask

  task automatic start_seq(logic [7:0] b);
    int len;
    len = lead_len(b);
    if (len >= 2) begin
      held_bytes[0] = b;
      held_cnt = 1;
      seq_len = len;
    end else begin
      add_result({23'b0, b});
    end
  endtask

  // expected code points for one accepted byte
  task automatic predict_byte(in_t t);
    logic [31:0] v;
    step_n = 0;
    if (held_cnt == 0 || seq_len < 2) begin
      held_cnt = 0;
      seq_len = 0;
      start_seq(t.byte_in);
    end else if ((t.byte_in & ContMask) == ContVal) begin
      if (held_cnt + 1 >= seq_len) begin
        v = {24'b0, held_bytes[0] & (LeadBits >> seq_len)};
        for (int i = 1; i < held_cnt; i++) v = (v << 6) | {26'b0, held_bytes[i][5:0]};
        v = (v << 6) | {26'b0, t.byte_in[5:0]};
        held_cnt = 0;
        seq_len = 0;
        add_result(v[CpW-1:0]);
      end else if (held_cnt < HoldDepth) begin
        held_bytes[held_cnt] = t.byte_in;
        held_cnt++;
      end
    end else begin
      // bad continuation: dump what is held, then retry this byte as a lead
      flush_held();
      start_seq(t.byte_in);
    end
    if (t.end_of_stream) flush_held();
    if (step_n > 0) step_res[step_n-1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) code_point_q.push_back(step_res[i]);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_byte(in_data_i);
        void'(byte_q.pop_front());
        bytes_taken <= bytes_taken + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled transaction holds
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() > TailItems && choppy && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= byte_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // one long receiver hold-off so the result register backs up into the input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (bytes_taken == PressAt && !hold_done) begin
      hold_left <= PressLen;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor and stall driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (code_point_q.size() == 0) begin
          report_mismatch("unexpected transaction", {1'b0, got.code_point}, '0);
        end else begin
          want = code_point_q.pop_front();
          if (got.code_point !== want.code_point)
            report_mismatch("code_point", {1'b0, got.code_point}, {1'b0, want.code_point});
          if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", {31'b0, got.last_of_run}, {31'b0, want.last_of_run});
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (byte_q.size() > TailItems && choppy && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic queue_byte(logic [7:0] b, logic eos);
    byte_q.push_back('{byte_in: b, end_of_stream: eos});
  endtask

  function automatic logic [7:0] rand_lead(int len);
    case (len)
      1:       return 8'($urandom_range(8'h00, 8'h7f));
      2:       return 8'hc0 | 8'($urandom_range(0, 31));
      3:       return 8'he0 | 8'($urandom_range(0, 15));
      4:       return 8'hf0 | 8'($urandom_range(0, 7));
      5:       return 8'hf8 | 8'($urandom_range(0, 3));
      default: return 8'hfc | 8'($urandom_range(0, 1));
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    int n_rand;
    int kind;
    int len;
    int n_cont;
    logic [7:0] b;

    // ascii extremes, lone continuations, never-valid bytes
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hfe, 1'b0);
    queue_byte(8'hff, 1'b1);
    // smallest 2-byte and largest 6-byte value
    queue_byte(8'hc0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hfd, 1'b0);
    for (int i = 0; i < 5; i++) queue_byte(8'hbf, 1'b0);
    // full hold then bad continuation with end of stream: six results
    queue_byte(8'hfc, 1'b0);
    for (int i = 0; i < 4; i++) queue_byte(8'h80, 1'b0);
    queue_byte(8'hc2, 1'b1);
    // end of stream in the middle of a sequence
    queue_byte(8'he0, 1'b0);
    queue_byte(8'h80, 1'b1);
    // bad continuation right after a 5-byte lead
    queue_byte(8'hf8, 1'b0);
    queue_byte(8'h41, 1'b0);

    // mostly well-formed sequences, some broken ones and some noise
    n_rand = 0;
    while (n_rand < 86) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(1, 6);
        queue_byte(rand_lead(len), $urandom_range(0, 15) == 0);
        for (int i = 1; i < len; i++)
          queue_byte(8'h80 | 8'($urandom_range(0, 63)), $urandom_range(0, 15) == 0);
        n_rand += len;
      end else if (kind < 9) begin
        len = $urandom_range(2, 6);
        n_cont = $urandom_range(0, len - 2);
        queue_byte(rand_lead(len), 1'b0);
        for (int i = 0; i < n_cont; i++)
          queue_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        b = 8'($urandom_range(0, 255));
        if ((b & ContMask) == ContVal) b ^= 8'h40;
        queue_byte(b, $urandom_range(0, 7) == 0);
        n_rand += n_cont + 2;
      end else begin
        queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        n_rand++;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((byte_q.size() != 0 || code_point_q.size() != 0) && cyc < CycLimit)
      @(posedge clk_i);

    if (cyc >= CycLimit) begin
      $display("tb: failure");
    end else begin
      repeat (10) @(posedge clk_i);
      if (errs == 0 && code_point_q.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/u8d_pkg.sv
hdl/u8d_step.sv
hdl/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
